FILE: hw/rtl/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg
// shared constants for the canny non-maximum suppression block
// ----------------------------------------------------------------------------
package cnms_pkg;

  // default sizing
  localparam int unsigned MAX_LINE_PIXELS_DEF = 1024;
  localparam int unsigned GRADIENT_BITS_DEF   = 16;
  localparam int unsigned FRACTION_BITS_DEF   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_SCALE = 3'd5;

  // register reset values
  localparam logic [10:0] IMAGE_WIDTH_RST     = 11'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST    = 16'd480;
  localparam logic [6:0]  BORDER_MARGIN_RST   = 7'd16;
  localparam logic [16:0] MAGNITUDE_LIMIT_RST = 17'd16000;
  localparam logic [19:0] MAGNITUDE_MAX_RST   = 20'd100000;
  localparam logic [9:0]  MAGNITUDE_SCALE_RST = 10'd100;

  // output item layout
  localparam int unsigned OUT_DATA_W = 48;

endpackage

FILE: hw/rtl/cnms_sqrt.sv
// ----------------------------------------------------------------------------
// cnms_sqrt
// iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module cnms_sqrt
  import cnms_pkg::*;
#(
  parameter int unsigned RootW = GRADIENT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*RootW-1:0]   rad_i,
  output logic                 done_o,
  output logic [RootW-1:0]     root_o
);

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned ShW  = RootW + 4;
  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;

  logic [ShW-1:0] rem_sh;
  logic [ShW-1:0] trial;
  logic           take;

  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = ShW'({root_q, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(RootW);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/canny_non_maximum_suppression.sv
// ----------------------------------------------------------------------------
// canny_non_maximum_suppression
// streaming 3x3 non-maximum suppression on x/y gradient pixels
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one pixel per item in raster order (x and y gradient in
//   tdata, frame start flag in tuser). m_axis returns one item for every
//   pixel at row >= 2 and column >= 2, describing the centre pixel one row
//   up and one column left: its position, edge strength and maximum flag.
//   the cfg channel writes the six registers and is always ready; write it
//   only while no item is in flight.
// timing:
//   one item at a time: the next pixel is taken only once the sequencer
//   is idle again. a pixel without output skips the window test. the
//   bit-serial square root and the single shared multiplier, used six
//   times per window test, set the processing time of each pixel.
// reset:
//   registers take their reset values, then a clearing pass zeroes all
//   MAX_LINE_PIXELS entries of the line memory; s_axis_tready stays low
//   during that pass.
// stall:
//   a finished item waits in the output register; the next pixel is still
//   taken and processed, and only its own result waits for the register.
// ----------------------------------------------------------------------------
module canny_non_maximum_suppression
  import cnms_pkg::*;
#(
  parameter int unsigned MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF,
  parameter int unsigned GRADIENT_BITS   = GRADIENT_BITS_DEF,
  parameter int unsigned FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // pixel input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // x_gradient, y_gradient
  input  logic [((2*GRADIENT_BITS+7)/8)*8-1:0] s_axis_tdata,
  // frame_start
  input  logic                                 s_axis_tuser,
  // result output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // centre_row, centre_column, edge_strength
  output logic [OUT_DATA_W-1:0]                m_axis_tdata,
  // is_maximum
  output logic                                 m_axis_tuser,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                cfg_data_i
);

  localparam int unsigned G     = GRADIENT_BITS;
  localparam int unsigned MulW  = (G + 1 > 11) ? G + 1 : 11;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned DiffW = ProdW + 1;
  localparam int unsigned RadW  = 2 * G;
  localparam int unsigned AddrW = $clog2(MAX_LINE_PIXELS);
  localparam int unsigned WidW  = ($clog2(MAX_LINE_PIXELS + 1) > 11) ?
                                  $clog2(MAX_LINE_PIXELS + 1) : 11;
  localparam int unsigned ColW  = WidW + 1;
  localparam int unsigned LimW  = (G > 17) ? G : 17;

  // sequencer codes
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SQX   = 4'd2;
  localparam logic [3:0] ST_SQY   = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_ROOT  = 4'd5;
  localparam logic [3:0] ST_SHIFT = 4'd6;
  localparam logic [3:0] ST_P0    = 4'd7;
  localparam logic [3:0] ST_P1    = 4'd8;
  localparam logic [3:0] ST_P2    = 4'd9;
  localparam logic [3:0] ST_P3    = 4'd10;
  localparam logic [3:0] ST_P4    = 4'd11;
  localparam logic [3:0] ST_P5    = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  typedef struct packed {
    logic signed [G-1:0] gx;
    logic signed [G-1:0] gy;
    logic [G-1:0]        mag;
  } pix_t;

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } ent_t;

  // configuration registers
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [6:0]  margin_q;
  logic [16:0] limit_q;
  logic [19:0] maxv_q;
  logic [9:0]  scale_q;

  // control
  logic [3:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q;
  logic [AddrW-1:0] col_cnt_q;
  logic [15:0]      row_cnt_q;
  logic             out_valid_q;

  // per-pixel datapath
  logic signed [G-1:0]     gx_q, gy_q;
  logic [AddrW-1:0]        col_q;
  logic [15:0]             row_q;
  logic [RadW-1:0]         rad_q;
  logic signed [ProdW-1:0] mul_q, bn_q;
  logic [DiffW-1:0]        t_q, d1_q, d2_q;
  logic                    inside_q;
  pix_t                    win_q [3][3];

  logic [15:0] out_row_q;
  logic [9:0]  out_col_q;
  logic [19:0] out_str_q;
  logic        out_max_q;

  // line memory: upper row (row - 2) and lower row (row - 1) per column
  ent_t             mem [MAX_LINE_PIXELS];
  ent_t             mem_rd_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  ent_t             mem_wdata;

  // ------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RST;
      height_q <= IMAGE_HEIGHT_RST;
      margin_q <= BORDER_MARGIN_RST;
      limit_q  <= MAGNITUDE_LIMIT_RST;
      maxv_q   <= MAGNITUDE_MAX_RST;
      scale_q  <= MAGNITUDE_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:     width_q  <= cfg_data_i[10:0];
        REG_IMAGE_HEIGHT:    height_q <= cfg_data_i[15:0];
        REG_BORDER_MARGIN:   margin_q <= cfg_data_i[6:0];
        REG_MAGNITUDE_LIMIT: limit_q  <= cfg_data_i[16:0];
        REG_MAGNITUDE_MAX:   maxv_q   <= cfg_data_i[19:0];
        REG_MAGNITUDE_SCALE: scale_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // effective line width, clamped to the memory depth
  logic [WidW-1:0] wid;
  assign wid = (WidW'(width_q) > WidW'(MAX_LINE_PIXELS)) ?
               WidW'(MAX_LINE_PIXELS) : WidW'(width_q);

  // ------------------------------------------------------------------
  // input acceptance and raster position
  // ------------------------------------------------------------------
  logic             in_acc;
  logic [AddrW-1:0] pos_col;
  logic [15:0]      pos_row;
  logic             col_wrap, row_wrap;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pos_col       = s_axis_tuser ? '0 : col_cnt_q;
  assign pos_row       = s_axis_tuser ? '0 : row_cnt_q;
  assign col_wrap      = (WidW'(pos_col) + WidW'(1)) >= wid;
  assign row_wrap      = (17'(pos_row) + 17'd1) >= 17'(height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_cnt_q <= '0;
        row_cnt_q <= row_wrap ? '0 : pos_row + 16'd1;
      end else begin
        col_cnt_q <= pos_col + AddrW'(1);
        row_cnt_q <= pos_row;
      end
    end
  end

  // ------------------------------------------------------------------
  // square root of gx^2 + gy^2
  // ------------------------------------------------------------------
  logic          sq_done;
  logic [G-1:0]  sq_root;
  logic [RadW-1:0] sq_rad;

  assign sq_rad = rad_q + RadW'($unsigned(mul_q));

  cnms_sqrt #(
    .RootW (G)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SUM),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  pix_t new_pix;
  always_comb begin
    new_pix.gx  = gx_q;
    new_pix.gy  = gy_q;
    new_pix.mag = sq_root;
  end

  // ------------------------------------------------------------------
  // line memory, zeroed after reset; one read on accept, one write-back in the shift step
  // ------------------------------------------------------------------
  always_comb begin
    mem_we          = (state_q == ST_CLEAR) || (state_q == ST_SHIFT);
    mem_waddr       = (state_q == ST_CLEAR) ? clr_cnt_q : col_q;
    mem_wdata.upper = mem_rd_q.lower;
    mem_wdata.lower = new_pix;
    if (state_q == ST_CLEAR) begin
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      mem_rd_q <= mem[pos_col];
    end
  end

  // ------------------------------------------------------------------
  // window test operands, selected by the centre pixel's gradient
  // ------------------------------------------------------------------
  pix_t                cen;
  logic                nonpos, xdom;
  logic signed [G:0]   abs_x, abs_y;
  logic signed [G-1:0] sel_a, sel_b;
  logic signed [G:0]   sel_c;
  logic [G-1:0]        sel_n1, sel_n2, sel_e1, sel_e2;

  always_comb begin
    cen    = win_q[1][1];
    abs_x  = cen.gx[G-1] ? -(G+1)'(cen.gx) : (G+1)'(cen.gx);
    abs_y  = cen.gy[G-1] ? -(G+1)'(cen.gy) : (G+1)'(cen.gy);
    xdom   = abs_x >= abs_y;
    // x*y <= 0
    nonpos = (cen.gx == '0) || (cen.gy == '0) || (cen.gx[G-1] != cen.gy[G-1]);
    sel_a  = xdom ? cen.gx : cen.gy;
    sel_b  = xdom ? cen.gy : cen.gx;
    if (nonpos) begin
      sel_c  = (G+1)'(cen.gx) + (G+1)'(cen.gy);
      sel_n1 = win_q[0][2].mag;
      sel_n2 = win_q[2][0].mag;
      sel_e1 = xdom ? win_q[1][2].mag : win_q[0][1].mag;
      sel_e2 = xdom ? win_q[1][0].mag : win_q[2][1].mag;
    end else begin
      sel_c  = xdom ? (G+1)'(cen.gy) - (G+1)'(cen.gx)
                    : (G+1)'(cen.gx) - (G+1)'(cen.gy);
      sel_n1 = win_q[2][2].mag;
      sel_n2 = win_q[0][0].mag;
      sel_e1 = xdom ? win_q[1][2].mag : win_q[2][1].mag;
      sel_e2 = xdom ? win_q[1][0].mag : win_q[0][1].mag;
    end
  end

  // shared multiplier, one product per step
  logic                   mul_en;
  logic signed [MulW-1:0] mul_a, mul_b;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_SQX: begin
        mul_a = MulW'(gx_q);
        mul_b = MulW'(gx_q);
      end
      ST_SQY: begin
        mul_a = MulW'(gy_q);
        mul_b = MulW'(gy_q);
      end
      ST_P0: begin
        mul_a = MulW'(sel_a);
        mul_b = MulW'(cen.mag);
      end
      ST_P1: begin
        mul_a = MulW'(sel_b);
        mul_b = MulW'(sel_n1);
      end
      ST_P2: begin
        mul_a = MulW'(sel_c);
        mul_b = MulW'(sel_e1);
      end
      ST_P3: begin
        mul_a = MulW'(sel_b);
        mul_b = MulW'(sel_n2);
      end
      ST_P4: begin
        mul_a = MulW'(sel_c);
        mul_b = MulW'(sel_e2);
      end
      ST_P5: begin
        mul_a = MulW'(scale_q);
        mul_b = MulW'(cen.mag);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // |product| and |b*n - c*e|
  logic signed [DiffW-1:0] mul_x, diff;
  logic [DiffW-1:0]        mul_abs, diff_abs;

  assign mul_x    = DiffW'(mul_q);
  assign diff     = DiffW'(bn_q) - mul_x;
  assign mul_abs  = $unsigned(mul_x[DiffW-1] ? -mul_x : mul_x);
  assign diff_abs = $unsigned(diff[DiffW-1] ? -diff : diff);

  // position checks for the centre pixel
  logic            produce, in_area;
  logic [ColW-1:0] cx_w, m_w;
  logic [16:0]     cy_w, m_h;

  assign produce = (row_q >= 16'd2) && (col_q >= AddrW'(2)) &&
                   (wid >= WidW'(3)) && (height_q >= 16'd3);
  assign cx_w    = ColW'(col_q) - ColW'(1);
  assign m_w     = ColW'(margin_q);
  assign cy_w    = 17'(row_q) - 17'd1;
  assign m_h     = 17'(margin_q);
  assign in_area = (cx_w >= m_w) && ((cx_w + m_w) < ColW'(wid)) &&
                   (cy_w >= m_h) && ((cy_w + m_h) < 17'(height_q));

  // final decision
  logic             is_max, sat, out_free;
  logic [ProdW-1:0] scaled;
  logic [19:0]      strength;

  assign is_max   = inside_q && (t_q >= d1_q) && (t_q > d2_q);
  assign sat      = LimW'(cen.mag) >= LimW'(limit_q);
  assign scaled   = $unsigned(mul_q) >> FRACTION_BITS;
  assign strength = !is_max ? 20'd0 :
                    sat ? maxv_q :
                    (scaled > ProdW'(maxv_q)) ? maxv_q : 20'(scaled);
  assign out_free = !out_valid_q || m_axis_tready;

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == AddrW'(MAX_LINE_PIXELS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_ROOT;
      ST_ROOT:  if (sq_done) state_d = ST_SHIFT;
      ST_SHIFT: state_d = produce ? ST_P0 : ST_IDLE;
      ST_P0:    state_d = ST_P1;
      ST_P1:    state_d = ST_P2;
      ST_P2:    state_d = ST_P3;
      ST_P3:    state_d = ST_P4;
      ST_P4:    state_d = ST_P5;
      ST_P5:    state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gx_q  <= s_axis_tdata[G-1:0];
      gy_q  <= s_axis_tdata[2*G-1:G];
      col_q <= pos_col;
      row_q <= pos_row;
    end
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    case (state_q)
      ST_SQY: rad_q <= RadW'($unsigned(mul_q));
      ST_SHIFT: begin
        inside_q <= in_area;
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= mem_rd_q.upper;
        win_q[1][2] <= mem_rd_q.lower;
        win_q[2][2] <= new_pix;
      end
      ST_P1: t_q  <= mul_abs;
      ST_P2: bn_q <= mul_q;
      ST_P3: d1_q <= diff_abs;
      ST_P4: bn_q <= mul_q;
      ST_P5: d2_q <= diff_abs;
      ST_DONE: begin
        if (out_free) begin
          out_row_q <= row_q - 16'd1;
          out_col_q <= 10'(col_q) - 10'd1;
          out_str_q <= strength;
          out_max_q <= is_max;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_str_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_max_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // one pixel in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second pixel taken while one is in flight");

  // root result only arrives while the sequencer waits for it
  a_root_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_ROOT)
    else $error("square root finished outside its wait step");

  // a suppressed pixel carries no strength
  a_suppressed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_max_q |-> out_str_q == '0)
    else $error("nonzero strength on a suppressed pixel");

endmodule

FILE: dv/canny_non_maximum_suppression_tb.sv
// ----------------------------------------------------------------------------
// canny_non_maximum_suppression_tb
// self-checking bench for the streaming 3x3 non-maximum suppression block
// ----------------------------------------------------------------------------
// pixels go in as gradient pairs in raster order, one item per handshake.
// a scoreboard class mirrors the line stores, the window and the position
// counters, predicts the item, if any, produced for each accepted pixel and checks
// the output stream field by field. the run covers small frames under many
// register settings, the extremes of the limit, maximum and scale registers, random idling on both
// sides, a long output hold-off and pauses until the pipe has drained.
// ----------------------------------------------------------------------------
module canny_non_maximum_suppression_tb;
  import cnms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_PIXELS = 1024;
  localparam int unsigned FRAC_BITS   = 4;
  localparam int unsigned DRAIN_WAIT  = 60;       // covers the slowest item in flight
  localparam longint      CYCLE_LIMIT = 2000000;
  localparam int unsigned NUM_PHASES  = 15;

  typedef struct {
    longint gx;
    longint gy;
    longint mag;
  } grad_pix_t;

  typedef struct {
    logic [15:0] row;
    logic [9:0]  col;
    logic [19:0] strength;
    logic        is_max;
  } edge_item_t;

  // --------------------------------------------------------------------------
  // scoreboard: suppression predictor plus store of pending edge items
  // --------------------------------------------------------------------------
  class nms_scoreboard;
    longint unsigned width_r, height_r, margin_r, limit_r, max_r, scale_r;
    grad_pix_t upper_line[LINE_PIXELS];
    grad_pix_t lower_line[LINE_PIXELS];
    grad_pix_t win[3][3];   // [row 0 top][col 0 left]
    longint unsigned col_cnt, row_cnt;
    edge_item_t pending_edges[$];
    int errors;

    function new();
      grad_pix_t z;
      z = '{0, 0, 0};
      width_r = IMAGE_WIDTH_RST;
      height_r = IMAGE_HEIGHT_RST;
      margin_r = BORDER_MARGIN_RST;
      limit_r = MAGNITUDE_LIMIT_RST;
      max_r = MAGNITUDE_MAX_RST;
      scale_r = MAGNITUDE_SCALE_RST;
      foreach (upper_line[i]) begin
        upper_line[i] = z;
        lower_line[i] = z;
      end
      foreach (win[r, c]) win[r][c] = z;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:     width_r = val[10:0];
        REG_IMAGE_HEIGHT:    height_r = val[15:0];
        REG_BORDER_MARGIN:   margin_r = val[6:0];
        REG_MAGNITUDE_LIMIT: limit_r = val[16:0];
        REG_MAGNITUDE_MAX:   max_r = val[19:0];
        REG_MAGNITUDE_SCALE: scale_r = val[9:0];
        default: ;
      endcase
    endfunction

    function longint mag_of(longint v);
      longint res, bit_v;
      res = 0;
      bit_v = 64'h4000_0000_0000_0000;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    function longint absl(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // interpolated test: >= toward the gradient, > against it
    function bit centre_is_max();
      longint x, y, g, n, s, w, e, nw, ne, sw, se, t;
      x = win[1][1].gx; y = win[1][1].gy; g = win[1][1].mag;
      n = win[0][1].mag; s = win[2][1].mag;
      w = win[1][0].mag; e = win[1][2].mag;
      nw = win[0][0].mag; ne = win[0][2].mag;
      sw = win[2][0].mag; se = win[2][2].mag;
      if (x * y <= 0) begin
        if (absl(x) >= absl(y)) begin
          t = absl(x * g);
          return t >= absl(y * ne - (x + y) * e) && t > absl(y * sw - (x + y) * w);
        end
        t = absl(y * g);
        return t >= absl(x * ne - (y + x) * n) && t > absl(x * sw - (y + x) * s);
      end
      if (absl(x) >= absl(y)) begin
        t = absl(x * g);
        return t >= absl(y * se + (x - y) * e) && t > absl(y * nw + (x - y) * w);
      end
      t = absl(y * g);
      return t >= absl(x * se + (y - x) * s) && t > absl(x * nw + (y - x) * n);
    endfunction

    function void note_pixel(logic signed [15:0] xg, logic signed [15:0] yg, logic fs);
      longint unsigned wid, col, row, strength;
      longint cx, cy, m;
      grad_pix_t p;
      edge_item_t it;
      bit in_area, flag;
      wid = (width_r > LINE_PIXELS) ? LINE_PIXELS : width_r;
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      col = col_cnt;
      row = row_cnt;
      if (col >= LINE_PIXELS) col = 0;
      p.gx = xg;
      p.gy = yg;
      p.mag = mag_of(p.gx * p.gx + p.gy * p.gy);
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = upper_line[col];
      win[1][2] = lower_line[col];
      win[2][2] = p;
      upper_line[col] = lower_line[col];
      lower_line[col] = p;
      if (row >= 2 && col >= 2 && wid >= 3 && height_r >= 3) begin
        cx = col - 1;
        cy = row - 1;
        m = margin_r;
        in_area = cx >= m && cx < longint'(wid) - m && cy >= m &&
                  cy < longint'(height_r) - m;
        flag = in_area && centre_is_max();
        strength = 0;
        if (flag) begin
          if (win[1][1].mag >= longint'(limit_r)) begin
            strength = max_r;
          end else begin
            strength = (scale_r * win[1][1].mag) >> FRAC_BITS;
            if (strength > max_r) strength = max_r;
          end
        end
        it.row = cy[15:0];
        it.col = cx[9:0];
        it.strength = strength[19:0];
        it.is_max = flag;
        pending_edges.push_back(it);
      end
      if (col + 1 >= wid) begin
        col_cnt = 0;
        row_cnt = (row + 1 >= height_r) ? 0 : ((row + 1) & 16'hFFFF);
      end else begin
        col_cnt = col + 1;
        row_cnt = row;
      end
    endfunction

    function void check_edge(logic [OUT_DATA_W-1:0] data, logic user);
      edge_item_t exp_it;
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected edge item %h / %b", $time, data, user);
        errors++;
        return;
      end
      exp_it = pending_edges.pop_front();
      if (data[15:0] !== exp_it.row) begin
        $display("%0t: centre_row expected %0d actual %0d", $time, exp_it.row, data[15:0]);
        errors++;
      end
      if (data[25:16] !== exp_it.col) begin
        $display("%0t: centre_column expected %0d actual %0d", $time, exp_it.col,
                 data[25:16]);
        errors++;
      end
      if (data[45:26] !== exp_it.strength) begin
        $display("%0t: edge_strength expected %0d actual %0d", $time, exp_it.strength,
                 data[45:26]);
        errors++;
      end
      if (user !== exp_it.is_max) begin
        $display("%0t: is_maximum expected %b actual %b", $time, exp_it.is_max, user);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, dut
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;     // x_gradient, y_gradient
  logic                  s_tuser = 1'b0;   // frame_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // centre_row, centre_column, edge_strength
  logic                  m_tuser;          // is_maximum
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nms_scoreboard sb = new();
  int  tx_idle_pct = 33;
  int  rx_idle_pct = 65;
  bit  hold_req = 1'b0;
  longint cycles = 0;

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  canny_non_maximum_suppression i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // monitors: sampled right after the edge, so they see pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) sb.note_pixel(s_tdata[15:0], s_tdata[31:16], s_tuser);
    if (rst_ni && m_tvalid && m_tready) sb.check_edge(m_tdata, m_tuser);
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  task automatic send_pixel(logic [15:0] xg, logic [15:0] yg, logic fs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {yg, xg};
    s_tuser <= fs;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // valid stays high across back-to-back writes; setup drops it at the end
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // sender pause until every pending edge item is back and the pipe is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_edges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic setup(int w, int h, int mg, int lim, int mx, int sc);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_BORDER_MARGIN, CFG_DATA_W'(mg));
    write_reg(REG_MAGNITUDE_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_MAGNITUDE_MAX, CFG_DATA_W'(mx));
    write_reg(REG_MAGNITUDE_SCALE, CFG_DATA_W'(sc));
    cfg_valid <= 1'b0;
  endtask

  // mostly small gradients so neighbours compete, plus full range and extremes
  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  logic [15:0] dir_x[10] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                             16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF};
  logic [15:0] dir_y[10] = '{16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000,
                             16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001};

  initial begin
    int w, h, mg, lim, mx, sc, n_items, frame_len;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 5x5 frame, margin 1, extremes of gradients and of limit, maximum and scale
    setup(5, 5, 1, 131071, 1048575, 1023);
    for (int i = 0; i < 25; i++) begin
      send_pixel(dir_x[i % 10], dir_y[(i * 3) % 10], i == 0);
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 10);
      mg = $urandom_range(1, 3);
      lim = $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 5000);
      mx = $urandom_range(0, 1048575);
      sc = $urandom_range(0, 1023);
      n_items = 100;
      case (ph)
        0: begin w = 3; h = 3; mg = 1; lim = 0; end
        1: begin w = 1024; h = 65535; mg = 64; n_items = 40; end
        2: begin sc = 0; mx = 0; end
        3: begin sc = 1023; mx = 1048575; lim = 131071; end
        4: begin w = 11; h = 65535; mg = 64; end
        default: ;
      endcase
      // sender idle 33 / receiver 65, then swapped, then none
      if (ph < 5) begin
        tx_idle_pct = 33; rx_idle_pct = 65;
      end else if (ph < 10) begin
        tx_idle_pct = 65; rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      setup(w, h, mg, lim, mx, sc);
      frame_len = (w > 1024 ? 1024 : w) * h;
      for (int k = 0; k < n_items; k++) begin
        if (ph == 7 && k == 10) hold_req = 1'b1;   // back-pressure fills the block
        // frames start cleanly, with the odd stray frame start
        send_pixel(rand_grad(), rand_grad(), (k % frame_len == 0) || ($urandom_range(0, 99) < 3));
      end
      drain();
    end

    sb.errors += sb.pending_edges.size();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: canny_non_maximum_suppression.f
hw/rtl/cnms_pkg.sv
hw/rtl/cnms_sqrt.sv
hw/rtl/canny_non_maximum_suppression.sv
dv/canny_non_maximum_suppression_tb.sv
